// ----- rtl/best_fit_hole_allocator_assert.svh -----
`ifndef BEST_FIT_HOLE_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HOLE_ALLOCATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BFHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bfha_pkg.sv -----
package bfha_pkg;

  localparam int HOLE_COUNT_W = 6;
  localparam int INDEX_W      = 5;
  localparam int SIZE_W       = 16;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Register index is paddr[2].
  localparam logic REG_HOLE_COUNT = 1'b0;

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] hole_index;
    logic [SIZE_W-1:0]  size;
  } in_item_t;

  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] chosen_hole;
    logic [SIZE_W-1:0]  space_left;
  } out_item_t;

endpackage

// ----- rtl/best_fit_hole_allocator.sv -----
// Load: result valid the cycle after the input transfer.
// Allocate: one comparator walks the first min(hole_count, MAX_HOLES) entries of the hole table,
//   one RAM entry per cycle, then an update state writes the result; a zero count skips the walk and refuses.
// One item at a time; the next item is taken the cycle after the result transfer.
// Reset (synchronous, rst high): hole_count goes to 0 and every hole reads as free size 0.
module best_fit_hole_allocator #(
  parameter int MAX_HOLES = 32,
  parameter int SIZE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bfha_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bfha_pkg::out_item_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfha_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bfha_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bfha_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  import bfha_pkg::*;

  localparam int IW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0]              state;
  logic [HOLE_COUNT_W-1:0] hole_count;
  logic [MAX_HOLES-1:0]    valid;
  logic [SIZE_BITS-1:0]    req;
  logic [IW-1:0]           cmp_idx;
  logic                    found;
  logic [IW-1:0]           best_idx;
  logic [SIZE_BITS-1:0]    best_val;
  logic                    rd_vld;

  logic                    in_fire;
  logic                    cfg_we;
  logic [31:0]             limit_w;
  logic [CW-1:0]           limit;
  logic                    scan_last;
  logic [31:0]             size_w;
  logic [SIZE_BITS-1:0]    size_cut;
  logic [31:0]             idx_w;
  logic [IW-1:0]           load_addr;
  logic                    load_in_range;
  logic [SIZE_BITS-1:0]    cur_val;
  logic                    fits;
  logic                    better;
  logic [SIZE_BITS-1:0]    remain;
  logic [31:0]             best_w;
  logic [31:0]             remain_w;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [SIZE_BITS-1:0]    ram_wdata;
  logic                    ram_re;
  logic [IW-1:0]           ram_raddr;
  logic [SIZE_BITS-1:0]    ram_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_HOLE_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOLE_COUNT) begin
      prdata[HOLE_COUNT_W-1:0] = hole_count;
    end
  end

  // Input decode
  assign in_stall      = (state != ST_IDLE);
  assign in_fire       = in_valid && !in_stall;
  assign size_w        = 32'(in_data.size);
  assign size_cut      = size_w[SIZE_BITS-1:0];
  assign idx_w         = 32'(in_data.hole_index);
  assign load_addr     = idx_w[IW-1:0];
  assign load_in_range = (idx_w < 32'(MAX_HOLES));

  // Clamp the search length to the table size
  assign limit_w   = (32'(hole_count) > 32'(MAX_HOLES)) ? 32'(MAX_HOLES) : 32'(hole_count);
  assign limit     = limit_w[CW-1:0];
  assign scan_last = ((CW'(cmp_idx) + CW'(1)) == limit);

  // Shared compare unit
  assign cur_val = rd_vld ? ram_rdata : '0;
  assign fits    = (cur_val >= req);
  assign better  = !found || (cur_val < best_val);
  assign remain  = best_val - req;

  assign best_w   = 32'(best_idx);
  assign remain_w = 32'(remain);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_addr;
    ram_wdata = size_cut;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      ST_IDLE: begin
        ram_we = in_fire && (in_data.command == CMD_LOAD) && load_in_range;
        ram_re = in_fire && (in_data.command == CMD_ALLOC);
      end
      ST_SCAN: begin
        ram_re    = !scan_last;
        ram_raddr = cmp_idx + IW'(1);
      end
      ST_UPDATE: begin
        ram_we    = found;
        ram_waddr = best_idx;
        ram_wdata = remain;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bfha_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(MAX_HOLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Valid bit travels with the read data; an unwritten hole reads as zero
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld <= valid[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hole_count <= '0;
      valid      <= '0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (cfg_we) begin
        hole_count <= pwdata[HOLE_COUNT_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            req     <= size_cut;
            found   <= 1'b0;
            cmp_idx <= '0;
            if (in_data.command == CMD_LOAD) begin
              if (load_in_range) begin
                valid[load_addr] <= 1'b1;
              end
              out_data  <= '0;
              out_valid <= 1'b1;
              state     <= ST_RESP;
            end else if (limit == '0) begin
              out_data  <= '0;
              out_valid <= 1'b1;
              state     <= ST_RESP;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fits && better) begin
            found    <= 1'b1;
            best_idx <= cmp_idx;
            best_val <= cur_val;
          end
          if (scan_last) begin
            state <= ST_UPDATE;
          end else begin
            cmp_idx <= cmp_idx + IW'(1);
          end
        end
        ST_UPDATE: begin
          if (found) begin
            valid[best_idx]      <= 1'b1;
            out_data.granted     <= 1'b1;
            out_data.chosen_hole <= best_w[INDEX_W-1:0];
            out_data.space_left  <= remain_w[SIZE_W-1:0];
          end else begin
            out_data <= '0;
          end
          out_valid <= 1'b1;
          state     <= ST_RESP;
        end
        ST_RESP: begin
          // Hold the result until the transfer completes
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bfha_ram.sv -----
module bfha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bfha_checker.sv -----
`include "best_fit_hole_allocator_assert.svh"

module bfha_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bfha_pkg::out_item_t out_data
);

  import bfha_pkg::*;

  `BFHA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `BFHA_ASSERT_NOW(a_refused_zero, clk, rst, out_valid && !out_data.granted, (out_data.chosen_hole == '0) && (out_data.space_left == '0), "refused result has nonzero fields")
  `BFHA_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "input taken while an item is in flight")
  `BFHA_ASSERT_NOW(a_busy_with_result, clk, rst, out_valid, in_stall, "input open while a result waits")

endmodule

bind best_fit_hole_allocator bfha_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- bench/tb_best_fit_hole_allocator.sv -----
module tb_best_fit_hole_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bfha_pkg::*;

  localparam int NUM_HOLES = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES = 300;
  localparam logic [APB_ADDR_W-1:0] ADDR_HOLE_COUNT = {REG_HOLE_COUNT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [APB_ADDR_W-1:0]   addr;
    logic [APB_DATA_W-1:0]   wdata;
    in_item_t                item;
    logic                    typed;
    out_item_t               grant;
  } dir_row_t;

  localparam out_item_t NO_GRANT = '0;
  localparam in_item_t NO_ITEM = '0;

  localparam int DIR_ROWS = 30;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // no holes searched after reset
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd31, 16'hFFFF}, 1'b1, NO_GRANT},
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd32, NO_ITEM, 1'b0, NO_GRANT},
    // zero request fits an empty table: hole 0, nothing left
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, {1'b1, 5'd0, 16'd0}},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd31, 16'hFFFF}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd5, 16'd100}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd7, 16'd100}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd3, 16'd50}, 1'b1, NO_GRANT},
    // tie between holes 5 and 7
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'd60}, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'hFFFF}, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'hFFFF}, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'd1}, 1'b0, NO_GRANT},
    // count above the table size
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd63, NO_ITEM, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'd40}, 1'b0, NO_GRANT},
    '{ROW_CFG, ADDR_UNUSED, 32'd0, NO_ITEM, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'd1}, 1'b0, NO_GRANT},
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd1, NO_ITEM, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd0, 16'hFFFF}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd1, 16'hFFFF}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'h8000}, 1'b0, NO_GRANT},
    // hole 1 is outside the search
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'h8000}, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd10, 16'hAAAA}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd21, 16'h5555}, 1'b1, NO_GRANT},
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd32, NO_ITEM, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd10, 16'h5555}, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd21, 16'h0000}, 1'b0, NO_GRANT},
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd0, NO_ITEM, 1'b0, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_ALLOC, 5'd0, 16'd0}, 1'b1, NO_GRANT},
    '{ROW_ITEM, 3'd0, 32'd0, {CMD_LOAD, 5'd0, 16'd0}, 1'b1, NO_GRANT},
    '{ROW_CFG, ADDR_HOLE_COUNT, 32'd2, NO_ITEM, 1'b0, NO_GRANT}
  };

  localparam int PHASE_COUNTS [PHASES] = '{32, 0, 63, 1, 17, 32, 2, 40, 31, 33};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [SIZE_W-1:0] hole_free [NUM_HOLES];
  logic [HOLE_COUNT_W-1:0] search_count;
  out_item_t expected_grants [$];
  int errors = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;

  best_fit_hole_allocator DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_best_fit_hole_allocator: errors");
    $finish;
  end

  function automatic out_item_t best_fit_predict(in_item_t it);
    out_item_t r;
    int lim;
    int best;
    bit found;
    r = '0;
    best = 0;
    found = 1'b0;
    if (it.command == CMD_LOAD) begin
      hole_free[it.hole_index] = it.size;
      return r;
    end
    lim = (search_count > NUM_HOLES) ? NUM_HOLES : int'(search_count);
    for (int j = 0; j < lim; j++) begin
      if (hole_free[j] >= it.size && (!found || hole_free[j] < hole_free[best])) begin
        best = j;
        found = 1'b1;
      end
    end
    if (found) begin
      hole_free[best] = hole_free[best] - it.size;
      r.granted = 1'b1;
      r.chosen_hole = best[INDEX_W-1:0];
      r.space_left = hole_free[best];
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        out_item_t e;
        e = expected_grants.pop_front();
        if (out_data.granted !== e.granted) begin
          $error("granted: expected %0d, got %0d", e.granted, out_data.granted);
          errors++;
        end
        if (out_data.chosen_hole !== e.chosen_hole) begin
          $error("chosen_hole: expected %0d, got %0d", e.chosen_hole, out_data.chosen_hole);
          errors++;
        end
        if (out_data.space_left !== e.space_left) begin
          $error("space_left: expected %0d, got %0d", e.space_left, out_data.space_left);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall, with a long hold-off on request
  initial begin
    int seen;
    int hold_left;
    seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(in_item_t it, bit typed, out_item_t grant);
    out_item_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 36)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = best_fit_predict(it);
    expected_grants.push_back(typed ? grant : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HOLE_COUNT) search_count = data[HOLE_COUNT_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] load_size();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return SIZE_W'($urandom_range(4095));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] request_size();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return SIZE_W'($urandom_range(255));
      12, 13, 14, 15, 16: return SIZE_W'($urandom_range(4095));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t it;
    logic [APB_DATA_W-1:0] count_val;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    search_count = '0;
    foreach (hole_free[k]) hole_free[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG) begin
        drain();
        apb_write(DIR_TABLE[r].addr, DIR_TABLE[r].wdata);
      end else begin
        send_item(DIR_TABLE[r].item, DIR_TABLE[r].typed, DIR_TABLE[r].grant);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 4) begin
        send_idle_pct = 12;
        recv_idle_pct = 80;
      end else if (p < 7) begin
        send_idle_pct = 80;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      count_val = (p == PHASES - 1) ? APB_DATA_W'($urandom_range(63)) : PHASE_COUNTS[p];
      apb_write(ADDR_HOLE_COUNT, count_val);
      // back up the output while the sender keeps offering items
      if (p == 7) hold_requests++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        it.hole_index = INDEX_W'($urandom);
        if ($urandom_range(99) < 40) begin
          it.command = CMD_LOAD;
          it.size = load_size();
        end else begin
          it.command = CMD_ALLOC;
          it.size = request_size();
        end
        send_item(it, 1'b0, NO_GRANT);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_best_fit_hole_allocator: clean");
    end else begin
      $display("tb_best_fit_hole_allocator: errors");
    end
    $finish;
  end

endmodule
